>>> rtl/scr_pkg.sv
// ----------------------------------------------------------------------------
// scr_pkg
// shared types, widths and constants of the spectrum column renderer
// ----------------------------------------------------------------------------
package scr_pkg;

  localparam int IDX_W      = 5;
  localparam int LVL_W      = 8;
  localparam int PEAK_W     = 6;
  localparam int HUE_W      = 8;
  localparam int LED_W      = 11;
  localparam int PEAK_DEPTH = 32;
  // serpentine position before masking: holds 64*64-1 at the widest matrix
  localparam int POS_W      = 12;
  // width for compares of small values against the matrix parameters
  localparam int CMP_W      = 7;

  localparam int LEVEL_MAX   = 80;
  localparam int PEAK_DECAY  = 10;
  localparam int COL_BASE    = 31;
  localparam int MAX_RESULTS = 39;
  localparam int ODD_ROW     = 'h01;

  localparam int NUM_BUCKETS_DEF   = 32;
  localparam int MATRIX_WIDTH_DEF  = 30;
  localparam int MATRIX_HEIGHT_DEF = 40;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_START_HUE    = 2'd0;
  localparam logic [1:0] REG_ROW_HUE_STEP = 2'd1;
  localparam logic [1:0] REG_COL_HUE_STEP = 2'd2;

  typedef struct packed {
    logic [HUE_W-1:0] start_hue;
    logic [HUE_W-1:0] row_hue_step;
    logic [HUE_W-1:0] col_hue_step;
  } cfg_t;

  typedef struct packed {
    logic [LED_W-1:0] led_index;
    logic             lit;
    logic [HUE_W-1:0] hue;
  } pix_t;

endpackage

>>> rtl/scr_in_if.sv
// ----------------------------------------------------------------------------
// scr_in_if
// input channel: one spectrum bucket per transaction
// ----------------------------------------------------------------------------
interface scr_in_if;
  logic                      valid;
  logic                      ready;
  logic [scr_pkg::IDX_W-1:0] column_index;
  logic [scr_pkg::LVL_W-1:0] level;

  modport source (output valid, output column_index, output level, input ready);
  modport sink   (input valid, input column_index, input level, output ready);
endinterface

>>> rtl/scr_out_if.sv
// ----------------------------------------------------------------------------
// scr_out_if
// result channel: one row pixel per transaction
// ----------------------------------------------------------------------------
interface scr_out_if;
  logic                      valid;
  logic                      ready;
  logic [scr_pkg::LED_W-1:0] led_index;
  logic                      lit;
  logic [scr_pkg::HUE_W-1:0] hue;
  logic                      last;

  modport source (output valid, output led_index, output lit, output hue, output last,
                  input ready);
  modport sink   (input valid, input led_index, input lit, input hue, input last,
                  output ready);
endinterface

>>> rtl/scr_cfg_regs.sv
// ----------------------------------------------------------------------------
// scr_cfg_regs
// apb register file: start hue, row hue step, column hue step
// ----------------------------------------------------------------------------
module scr_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [scr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [scr_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [scr_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output scr_pkg::cfg_t                  cfg
);

  scr_pkg::cfg_t cfg_r;
  scr_pkg::cfg_t cfg_nxt;
  logic [1:0]    reg_sel;
  logic          wr_en;

  assign reg_sel = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_sel)
        scr_pkg::REG_START_HUE:    cfg_nxt.start_hue    = pwdata[scr_pkg::HUE_W-1:0];
        scr_pkg::REG_ROW_HUE_STEP: cfg_nxt.row_hue_step = pwdata[scr_pkg::HUE_W-1:0];
        scr_pkg::REG_COL_HUE_STEP: cfg_nxt.col_hue_step = pwdata[scr_pkg::HUE_W-1:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      scr_pkg::REG_START_HUE:
        prdata = scr_pkg::CFG_DATA_W'(cfg_r.start_hue);
      scr_pkg::REG_ROW_HUE_STEP:
        prdata = scr_pkg::CFG_DATA_W'(cfg_r.row_hue_step);
      scr_pkg::REG_COL_HUE_STEP:
        prdata = scr_pkg::CFG_DATA_W'(cfg_r.col_hue_step);
      default:
        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> rtl/scr_peak_store.sv
// ----------------------------------------------------------------------------
// scr_peak_store
// per-bucket peak hold: saturate, halve, decay and raise to the new height
// ----------------------------------------------------------------------------
module scr_peak_store (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [scr_pkg::IDX_W-1:0]  idx,
  input  logic [scr_pkg::LVL_W-1:0]  level,
  input  logic                       upd_en,
  output logic [scr_pkg::PEAK_W-1:0] peak_new
);

  logic [scr_pkg::PEAK_W-1:0] peak_r [scr_pkg::PEAK_DEPTH];
  logic [scr_pkg::LVL_W-1:0]  lvl_sat;
  logic [scr_pkg::PEAK_W-1:0] height;
  logic [scr_pkg::PEAK_W-1:0] peak_old;
  logic [scr_pkg::PEAK_W-1:0] peak_dec;

  always_comb begin
    lvl_sat  = (level > scr_pkg::LVL_W'(scr_pkg::LEVEL_MAX)) ?
               scr_pkg::LVL_W'(scr_pkg::LEVEL_MAX) : level;
    height   = lvl_sat[scr_pkg::PEAK_W:1];
    peak_old = peak_r[idx];
    peak_dec = (peak_old > scr_pkg::PEAK_W'(scr_pkg::PEAK_DECAY)) ?
               peak_old - scr_pkg::PEAK_W'(scr_pkg::PEAK_DECAY) : '0;
    peak_new = (height > peak_dec) ? height : peak_dec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < scr_pkg::PEAK_DEPTH; i++) begin
        peak_r[i] <= '0;
      end
    end else if (upd_en) begin
      peak_r[idx] <= peak_new;
    end
  end

endmodule

>>> rtl/scr_row_unit.sv
// ----------------------------------------------------------------------------
// scr_row_unit
// row datapath reused every row: lit test, hue accumulate, serpentine index
// ----------------------------------------------------------------------------
module scr_row_unit #(
  parameter int MATRIX_WIDTH  = scr_pkg::MATRIX_WIDTH_DEF,
  parameter int MATRIX_HEIGHT = scr_pkg::MATRIX_HEIGHT_DEF,
  parameter int ROW_W         = $clog2(MATRIX_HEIGHT)
) (
  input  logic [ROW_W-1:0]           row,
  input  logic [scr_pkg::PEAK_W-1:0] peak,
  input  logic [scr_pkg::POS_W-1:0]  base,
  input  logic [scr_pkg::POS_W-1:0]  x_even,
  input  logic [scr_pkg::POS_W-1:0]  x_odd,
  input  logic [scr_pkg::HUE_W-1:0]  hue_line,
  input  logic [scr_pkg::HUE_W-1:0]  col_add,
  input  logic [scr_pkg::HUE_W-1:0]  row_hue_step,
  output scr_pkg::pix_t              pix,
  output logic [scr_pkg::HUE_W-1:0]  hue_line_nxt,
  output logic [scr_pkg::POS_W-1:0]  base_nxt
);

  logic                      lit;
  logic [scr_pkg::HUE_W-1:0] hue_step;
  logic [scr_pkg::POS_W-1:0] pos;

  always_comb begin
    // lit when row > height_of_matrix - peak
    lit      = (scr_pkg::CMP_W'(row) + scr_pkg::CMP_W'(peak)) >
               scr_pkg::CMP_W'(MATRIX_HEIGHT);
    hue_step = hue_line + row_hue_step;
    hue_line_nxt = lit ? hue_step : hue_line;
    // odd rows run right to left on the strip
    pos = ((ROW_W'(row) & ROW_W'(scr_pkg::ODD_ROW)) != '0) ? base + x_odd : base + x_even;
    base_nxt = base - scr_pkg::POS_W'(MATRIX_WIDTH);
    pix.led_index = pos[scr_pkg::LED_W-1:0];
    pix.lit       = lit;
    pix.hue       = lit ? hue_step + col_add : '0;
  end

endmodule

>>> rtl/spectrum_column_renderer.sv
// ----------------------------------------------------------------------------
// spectrum_column_renderer
// led spectrum bar with peak hold, one column per input transaction
// ----------------------------------------------------------------------------
// Each input transaction with an index below NUM_BUCKETS updates the bucket's
// peak hold and, when the drawn column (31 minus the index) lies in the
// matrix and the held height is below the matrix height, emits rows
// MATRIX_HEIGHT-1 downward, at most 39, one per cycle while the output is not
// stalled, through a single row datapath under a small sequencer. A column
// passes an accept step, a setup step (peak read, decay and write back, column
// hue product) and then its min(MATRIX_HEIGHT-1, 39) row steps. The next
// column is accepted as soon as the final row sits in the output register. The
// peak store is flip-flops cleared by reset, so the block is ready right after
// reset.
module spectrum_column_renderer #(
  parameter int NUM_BUCKETS   = scr_pkg::NUM_BUCKETS_DEF,
  parameter int MATRIX_WIDTH  = scr_pkg::MATRIX_WIDTH_DEF,
  parameter int MATRIX_HEIGHT = scr_pkg::MATRIX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  scr_in_if.sink                         in_if,
  scr_out_if.source                      out_if,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [scr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [scr_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [scr_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  localparam int ROW_W    = $clog2(MATRIX_HEIGHT);
  localparam int NUM_ROWS = (MATRIX_HEIGHT - 1 < scr_pkg::MAX_RESULTS) ?
                            MATRIX_HEIGHT - 1 : scr_pkg::MAX_RESULTS;
  localparam logic [ROW_W-1:0] TOP_ROW  = ROW_W'(MATRIX_HEIGHT - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(MATRIX_HEIGHT - NUM_ROWS);
  localparam logic [scr_pkg::POS_W-1:0] TOP_BASE =
    scr_pkg::POS_W'((MATRIX_HEIGHT - 1) * MATRIX_WIDTH);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_ROWS  = 2'd2;

  scr_pkg::cfg_t cfg;

  logic [1:0]                 state_r, state_nxt;
  logic [scr_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic [scr_pkg::LVL_W-1:0]  lvl_r, lvl_nxt;
  logic [scr_pkg::PEAK_W-1:0] peak_r, peak_nxt;
  logic [ROW_W-1:0]           row_r, row_nxt;
  logic [scr_pkg::POS_W-1:0]  base_r, base_nxt;
  logic [scr_pkg::POS_W-1:0]  x_even_r, x_even_nxt;
  logic [scr_pkg::POS_W-1:0]  x_odd_r, x_odd_nxt;
  logic [scr_pkg::HUE_W-1:0]  hue_line_r, hue_line_nxt;
  logic [scr_pkg::HUE_W-1:0]  col_add_r, col_add_nxt;
  logic                       out_valid_r, out_valid_nxt;
  scr_pkg::pix_t              out_pix_r, out_pix_nxt;
  logic                       out_last_r, out_last_nxt;

  logic [scr_pkg::PEAK_W-1:0] peak_new;
  logic [scr_pkg::IDX_W-1:0]  column;
  logic                       idx_ok;
  logic                       emit;
  logic [12:0]                col_prod;
  logic                       out_free;
  scr_pkg::pix_t              pix;
  logic [scr_pkg::HUE_W-1:0]  unit_hue_line;
  logic [scr_pkg::POS_W-1:0]  unit_base;

  scr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  scr_peak_store u_peak (
    .clk      (clk),
    .rst_n    (rst_n),
    .idx      (idx_r),
    .level    (lvl_r),
    .upd_en   ((state_r == ST_SETUP) && idx_ok),
    .peak_new (peak_new)
  );

  scr_row_unit #(
    .MATRIX_WIDTH  (MATRIX_WIDTH),
    .MATRIX_HEIGHT (MATRIX_HEIGHT),
    .ROW_W         (ROW_W)
  ) u_row (
    .row          (row_r),
    .peak         (peak_r),
    .base         (base_r),
    .x_even       (x_even_r),
    .x_odd        (x_odd_r),
    .hue_line     (hue_line_r),
    .col_add      (col_add_r),
    .row_hue_step (cfg.row_hue_step),
    .pix          (pix),
    .hue_line_nxt (unit_hue_line),
    .base_nxt     (unit_base)
  );

  assign column   = scr_pkg::IDX_W'(scr_pkg::COL_BASE) - idx_r;
  assign idx_ok   = scr_pkg::CMP_W'(idx_r) < scr_pkg::CMP_W'(NUM_BUCKETS);
  assign emit     = idx_ok &&
                    (scr_pkg::CMP_W'(column) < scr_pkg::CMP_W'(MATRIX_WIDTH)) &&
                    (scr_pkg::CMP_W'(peak_new) < scr_pkg::CMP_W'(MATRIX_HEIGHT));
  assign col_prod = 13'(cfg.col_hue_step) * 13'(column);
  assign out_free = !out_valid_r || out_if.ready;

  assign in_if.ready      = (state_r == ST_IDLE);
  assign out_if.valid     = out_valid_r;
  assign out_if.led_index = out_pix_r.led_index;
  assign out_if.lit       = out_pix_r.lit;
  assign out_if.hue       = out_pix_r.hue;
  assign out_if.last      = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    lvl_nxt       = lvl_r;
    peak_nxt      = peak_r;
    row_nxt       = row_r;
    base_nxt      = base_r;
    x_even_nxt    = x_even_r;
    x_odd_nxt     = x_odd_r;
    hue_line_nxt  = hue_line_r;
    col_add_nxt   = col_add_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_pix_nxt   = out_pix_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          idx_nxt   = in_if.column_index;
          lvl_nxt   = in_if.level;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        peak_nxt     = peak_new;
        row_nxt      = TOP_ROW;
        base_nxt     = TOP_BASE;
        x_even_nxt   = scr_pkg::POS_W'(column);
        x_odd_nxt    = scr_pkg::POS_W'(MATRIX_WIDTH - 1) - scr_pkg::POS_W'(column);
        hue_line_nxt = cfg.start_hue;
        col_add_nxt  = col_prod[scr_pkg::HUE_W-1:0];
        state_nxt    = emit ? ST_ROWS : ST_IDLE;
      end
      ST_ROWS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pix_nxt   = pix;
          out_last_nxt  = (row_r == LAST_ROW);
          hue_line_nxt  = unit_hue_line;
          base_nxt      = unit_base;
          row_nxt       = row_r - ROW_W'(1);
          if (row_r == LAST_ROW) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    lvl_r      <= lvl_nxt;
    peak_r     <= peak_nxt;
    row_r      <= row_nxt;
    base_r     <= base_nxt;
    x_even_r   <= x_even_nxt;
    x_odd_r    <= x_odd_nxt;
    hue_line_r <= hue_line_nxt;
    col_add_r  <= col_add_nxt;
    out_pix_r  <= out_pix_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule
